FILE: hw/rtl/srt_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the static route table unit
// no dependencies

package srt_pkg;

  // command codes on the command channel
  typedef enum logic [2:0] {
    CMD_ADD_STATIC = 3'd0,
    CMD_DEL_STATIC = 3'd1,
    CMD_ADD_BH     = 3'd2,
    CMD_DEL_BH     = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_INTF_SCAN  = 3'd5
  } cmd_e;

  // action codes on the result channel
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_DEL    = 3'd2,
    ACT_ADD_BH = 3'd3,
    ACT_DEL_BH = 3'd4
  } action_e;

  // status codes on the final result item
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ADDR    = 3'd1,
    ST_RIP_DIST    = 3'd2,
    ST_OSPF_DIST   = 3'd3,
    ST_FULL        = 3'd4,
    ST_METRIC_REPL = 3'd5,
    ST_GW_REPL     = 3'd6
  } status_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_RIP_DIST   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OSPF_DIST  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REDIST_RIP = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REDIST_OSPF = 3'd3;

  localparam logic [7:0] RIP_DIST_RST = 8'd120;
  localparam logic [7:0] OSPF_DIST_RST = 8'd110;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PRE  = 4'b0100,
    S_LAST = 4'b1000
  } state_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic        blackhole;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  metric;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // one result item
  typedef struct packed {
    action_e     action;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  metric;
    logic [1:0]  redist;
    status_e     status;
    logic        last;
  } res_t;

endpackage

FILE: hw/rtl/srt_cmd_if.sv
`timescale 1ns / 1ps
// command channel of the static route table unit
// valid/ready handshake with the command payload, no dependencies

interface srt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] prefix;
  logic [31:0] prefix_mask;
  logic [31:0] gateway;
  logic [7:0]  metric;
  logic [31:0] intf_addr;
  logic [31:0] intf_netmask;

  modport source (
    output valid, command, prefix, prefix_mask, gateway, metric, intf_addr, intf_netmask,
    input  ready
  );
  modport sink (
    input  valid, command, prefix, prefix_mask, gateway, metric, intf_addr, intf_netmask,
    output ready
  );
endinterface

FILE: hw/rtl/srt_res_if.sv
`timescale 1ns / 1ps
// result channel of the static route table unit
// valid/ready handshake with the action item payload, no dependencies

interface srt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] route_prefix;
  logic [31:0] route_mask;
  logic [31:0] route_gateway;
  logic [7:0]  route_metric;
  logic [1:0]  redist_targets;
  logic [2:0]  status;
  logic        last;

  modport source (
    output valid, action, route_prefix, route_mask, route_gateway, route_metric,
           redist_targets, status, last,
    input  ready
  );
  modport sink (
    input  valid, action, route_prefix, route_mask, route_gateway, route_metric,
           redist_targets, status, last,
    output ready
  );
endinterface

FILE: hw/rtl/static_route_table_unit.sv
`timescale 1ns / 1ps
// static route table unit: command sequencer over one entry memory
// depends on srt_pkg, srt_cmd_if, srt_res_if and srt_ram
//
// Usage:
//   cmd_i takes one route command per transfer; res_o returns the action
//   items it causes, the final one with last set and the command's status.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the distance and redistribution
//   registers; write them only while no command is in flight.
// Timing:
//   a rejected command (host bits, reserved metric, unknown code) skips the
//   sweep and goes straight to its final item. Any other command reads all
//   TABLE_DEPTH entries one per cycle while no scan item is stalled, and adds a
//   delete item ahead of the final one for a metric or gateway replacement.
//   The first result item is registered; a new command is taken once the
//   previous one has handed its final item to the output register.
// Reset:
//   all entries become free at once (per-entry valid flops), registers take
//   their reset values, no clearing pass. A stalled receiver freezes the
//   table sweep while an item waits to be taken.

module static_route_table_unit
  import srt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  srt_cmd_if.sink             cmd_i,
  srt_res_if.source           res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] CntEnd = CntW'(TABLE_DEPTH);

  // configuration registers
  logic [7:0] rip_dist_q, ospf_dist_q;
  logic       redist_rip_q, redist_ospf_q;
  logic [1:0] rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rip_dist_q    <= RIP_DIST_RST;
      ospf_dist_q   <= OSPF_DIST_RST;
      redist_rip_q  <= 1'b0;
      redist_ospf_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RIP_DIST:    rip_dist_q    <= cfg_wdata_i;
        CFG_OSPF_DIST:   ospf_dist_q   <= cfg_wdata_i;
        CFG_REDIST_RIP:  redist_rip_q  <= cfg_wdata_i[0];
        CFG_REDIST_OSPF: redist_ospf_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign rd = {redist_ospf_q, redist_rip_q};

  // sequencer and tracking state
  state_e         state_q, state_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic           chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic [TABLE_DEPTH-1:0] vld_q, vld_d;

  logic           exact_fnd_q, exact_fnd_d;
  logic [IdxW-1:0] exact_idx_q, exact_idx_d;
  logic [7:0]     exact_met_q, exact_met_d;
  logic           pfx_fnd_q, pfx_fnd_d;
  logic [IdxW-1:0] pfx_idx_q, pfx_idx_d;
  logic [31:0]    pfx_gw_q, pfx_gw_d;
  logic [7:0]     pfx_met_q, pfx_met_d;
  logic           free_fnd_q, free_fnd_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic           bh_fnd_q, bh_fnd_d;
  logic [IdxW-1:0] bh_idx_q, bh_idx_d;

  // latched command
  logic [2:0]  cmd_q;
  logic [31:0] prefix_q, mask_q, gw_q, ia_q, im_q;
  logic [7:0]  met_q;
  logic        rej_q, rej_d;
  status_e     rej_st_q, rej_st_d;

  // memory port
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata, ent;
  logic [EntryW-1:0] ram_rdata;

  // output register
  logic out_vld_q, out_load, out_free;
  res_t out_q, out_d;

  logic accept;
  logic chk_v, chk_static, chk_pm, chk_exact, chk_bh, chk_intf, emit_scan, stall;
  logic gw_repl;

  srt_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent = entry_t'(ram_rdata);

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_vld_q || res_o.ready;

  // early rejects from the command fields and the distance registers
  always_comb begin
    rej_d    = 1'b0;
    rej_st_d = ST_OK;
    if ((cmd_i.command == CMD_ADD_STATIC || cmd_i.command == CMD_DEL_STATIC ||
         cmd_i.command == CMD_ADD_BH || cmd_i.command == CMD_DEL_BH) &&
        ((cmd_i.prefix & ~cmd_i.prefix_mask) != 32'd0)) begin
      rej_d    = 1'b1;
      rej_st_d = ST_BAD_ADDR;
    end else if (cmd_i.command == CMD_ADD_STATIC && cmd_i.metric == rip_dist_q) begin
      rej_d    = 1'b1;
      rej_st_d = ST_RIP_DIST;
    end else if (cmd_i.command == CMD_ADD_STATIC && cmd_i.metric == ospf_dist_q) begin
      rej_d    = 1'b1;
      rej_st_d = ST_OSPF_DIST;
    end else if (!(cmd_i.command == CMD_ADD_STATIC || cmd_i.command == CMD_DEL_STATIC ||
                   cmd_i.command == CMD_ADD_BH || cmd_i.command == CMD_DEL_BH ||
                   cmd_i.command == CMD_CLEAR || cmd_i.command == CMD_INTF_SCAN)) begin
      rej_d    = 1'b1;
      rej_st_d = ST_OK;
    end
  end

  // compare the entry held in the memory read register against the command
  assign chk_v      = vld_q[chk_idx_q];
  assign chk_static = chk_v && !ent.blackhole;
  assign chk_pm     = (ent.prefix == prefix_q) && (ent.mask == mask_q);
  assign chk_exact  = chk_static && chk_pm && (ent.gateway == gw_q);
  assign chk_bh     = chk_v && ent.blackhole && chk_pm;
  assign chk_intf   = chk_static && ((ia_q & im_q) == (ent.gateway & im_q));
  assign emit_scan  = chk_vld_q && ((cmd_q == CMD_CLEAR && chk_v) ||
                                    (cmd_q == CMD_INTF_SCAN && chk_intf));
  assign stall      = emit_scan && !out_free;
  assign gw_repl    = pfx_fnd_q && (pfx_met_q == met_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    vld_d       = vld_q;
    exact_fnd_d = exact_fnd_q;
    exact_idx_d = exact_idx_q;
    exact_met_d = exact_met_q;
    pfx_fnd_d   = pfx_fnd_q;
    pfx_idx_d   = pfx_idx_q;
    pfx_gw_d    = pfx_gw_q;
    pfx_met_d   = pfx_met_q;
    free_fnd_d  = free_fnd_q;
    free_idx_d  = free_idx_q;
    bh_fnd_d    = bh_fnd_q;
    bh_idx_d    = bh_idx_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    out_load    = 1'b0;
    out_d       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_idx_d    = '0;
          chk_vld_d   = 1'b0;
          exact_fnd_d = 1'b0;
          pfx_fnd_d   = 1'b0;
          free_fnd_d  = 1'b0;
          bh_fnd_d    = 1'b0;
          state_d     = rej_d ? S_LAST : S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // evaluate the entry in the check stage
          if (chk_vld_q) begin
            if (!chk_v && !free_fnd_q) begin
              free_fnd_d = 1'b1;
              free_idx_d = chk_idx_q;
            end
            if (chk_exact && !exact_fnd_q) begin
              exact_fnd_d = 1'b1;
              exact_idx_d = chk_idx_q;
              exact_met_d = ent.metric;
            end
            if (chk_static && chk_pm && !pfx_fnd_q) begin
              pfx_fnd_d = 1'b1;
              pfx_idx_d = chk_idx_q;
              pfx_gw_d  = ent.gateway;
              pfx_met_d = ent.metric;
            end
            if (chk_bh && !bh_fnd_q) begin
              bh_fnd_d = 1'b1;
              bh_idx_d = chk_idx_q;
            end
            if (emit_scan) begin
              out_load      = 1'b1;
              out_d.prefix  = ent.prefix;
              out_d.mask    = ent.mask;
              out_d.status  = ST_OK;
              out_d.last    = 1'b0;
              if (cmd_q == CMD_CLEAR) begin
                vld_d[chk_idx_q] = 1'b0;
                if (ent.blackhole) begin
                  out_d.action = ACT_DEL_BH;
                end else begin
                  out_d.action  = ACT_DEL;
                  out_d.gateway = ent.gateway;
                  out_d.metric  = ent.metric;
                  out_d.redist  = rd;
                end
              end else begin
                out_d.action  = ACT_ADD;
                out_d.gateway = ent.gateway;
                out_d.metric  = ent.metric;
              end
            end
          end
          // issue the next memory read
          if (rd_idx_q != CntEnd) begin
            ram_re    = 1'b1;
            chk_vld_d = 1'b1;
            chk_idx_d = rd_idx_q[IdxW-1:0];
            rd_idx_d  = rd_idx_q + 1'b1;
          end else begin
            chk_vld_d = 1'b0;
            if (!chk_vld_q) begin
              if (cmd_q == CMD_ADD_STATIC && (exact_fnd_q || gw_repl)) begin
                state_d = S_PRE;
              end else begin
                state_d = S_LAST;
              end
            end
          end
        end
      end

      // kernel delete ahead of a metric or gateway replacement
      S_PRE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_d.action  = ACT_DEL;
          out_d.prefix  = prefix_q;
          out_d.mask    = mask_q;
          out_d.gateway = exact_fnd_q ? gw_q : pfx_gw_q;
          out_d.metric  = exact_fnd_q ? exact_met_q : pfx_met_q;
          out_d.redist  = rd;
          out_d.status  = ST_OK;
          out_d.last    = 1'b0;
          state_d       = S_LAST;
        end
      end

      // final item and table update
      S_LAST: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          state_d    = S_IDLE;
          if (rej_q) begin
            out_d.status = rej_st_q;
          end else begin
            case (cmd_q)
              CMD_ADD_STATIC: begin
                ram_wdata = '{blackhole: 1'b0, prefix: prefix_q, mask: mask_q,
                              gateway: gw_q, metric: met_q};
                if (exact_fnd_q || gw_repl || free_fnd_q) begin
                  out_d.action  = ACT_ADD;
                  out_d.prefix  = prefix_q;
                  out_d.mask    = mask_q;
                  out_d.gateway = gw_q;
                  out_d.metric  = met_q;
                  out_d.redist  = rd;
                  ram_we        = 1'b1;
                end
                if (exact_fnd_q) begin
                  out_d.status = ST_METRIC_REPL;
                  ram_waddr    = exact_idx_q;
                end else if (gw_repl) begin
                  out_d.status = ST_GW_REPL;
                  ram_waddr    = pfx_idx_q;
                end else if (free_fnd_q) begin
                  out_d.status      = ST_OK;
                  ram_waddr         = free_idx_q;
                  vld_d[free_idx_q] = 1'b1;
                end else begin
                  out_d.status = ST_FULL;
                end
              end
              CMD_DEL_STATIC: begin
                out_d.action  = ACT_DEL;
                out_d.prefix  = prefix_q;
                out_d.mask    = mask_q;
                out_d.gateway = gw_q;
                out_d.redist  = rd;
                if (exact_fnd_q) begin
                  vld_d[exact_idx_q] = 1'b0;
                end
              end
              CMD_ADD_BH: begin
                ram_wdata = '{blackhole: 1'b1, prefix: prefix_q, mask: mask_q,
                              gateway: 32'd0, metric: 8'd0};
                if (!bh_fnd_q) begin
                  if (free_fnd_q) begin
                    out_d.action      = ACT_ADD_BH;
                    out_d.prefix      = prefix_q;
                    out_d.mask        = mask_q;
                    ram_we            = 1'b1;
                    ram_waddr         = free_idx_q;
                    vld_d[free_idx_q] = 1'b1;
                  end else begin
                    out_d.status = ST_FULL;
                  end
                end
              end
              CMD_DEL_BH: begin
                if (bh_fnd_q) begin
                  out_d.action     = ACT_DEL_BH;
                  out_d.prefix     = prefix_q;
                  out_d.mask       = mask_q;
                  vld_d[bh_idx_q]  = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_idx_q    <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      vld_q       <= '0;
      exact_fnd_q <= 1'b0;
      pfx_fnd_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      bh_fnd_q    <= 1'b0;
      rej_q       <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      vld_q       <= vld_d;
      exact_fnd_q <= exact_fnd_d;
      pfx_fnd_q   <= pfx_fnd_d;
      free_fnd_q  <= free_fnd_d;
      bh_fnd_q    <= bh_fnd_d;
      if (accept) begin
        rej_q <= rej_d;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    exact_idx_q <= exact_idx_d;
    exact_met_q <= exact_met_d;
    pfx_idx_q   <= pfx_idx_d;
    pfx_gw_q    <= pfx_gw_d;
    pfx_met_q   <= pfx_met_d;
    free_idx_q  <= free_idx_d;
    bh_idx_q    <= bh_idx_d;
    if (accept) begin
      cmd_q    <= cmd_i.command;
      prefix_q <= cmd_i.prefix;
      mask_q   <= cmd_i.prefix_mask;
      gw_q     <= cmd_i.gateway;
      met_q    <= cmd_i.metric;
      ia_q     <= cmd_i.intf_addr;
      im_q     <= cmd_i.intf_netmask;
      rej_st_q <= rej_st_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // result channel
  assign res_o.valid          = out_vld_q;
  assign res_o.action         = out_q.action;
  assign res_o.route_prefix   = out_q.prefix;
  assign res_o.route_mask     = out_q.mask;
  assign res_o.route_gateway  = out_q.gateway;
  assign res_o.route_metric   = out_q.metric;
  assign res_o.redist_targets = out_q.redist;
  assign res_o.status         = out_q.status;
  assign res_o.last           = out_q.last;

endmodule

FILE: hw/rtl/srt_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read memory with registered read data
// no dependencies

module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
